### rtl/cor_pkg.sv
// Shared types and constants for the camera orbit rotation pipeline.
`default_nettype none

package cor_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TRIG_STEPS = 16;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;

    // angle working width: holds the negated input and twice a full turn
    localparam int ANG_W = (FRAC_BITS + 11 > 28) ? FRAC_BITS + 11 : 28;

    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [25:0] DEG_TO_RAD  = 26'sd18740330;

    localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(360 << FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_FULL2   = ANG_W'(720 << FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(180 << FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 << FRAC_BITS);

    localparam logic [29:0] ATAN_Q30 [24] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127
    };

    // one word in flight: vec[0] is eye, vec[1] is up
    typedef struct packed {
        logic [1:0][2:0][31:0] vec;
        logic                  zero;
        logic [2:0]            sgn;
        logic                  flip;
        logic [ANG_W-1:0]      ang;
        logic [2:0][29:0]      mag;
        logic [33:0]           cx;
        logic [33:0]           cy;
        logic [33:0]           cz;
        logic [62:0]           sq_rem;
        logic [62:0]           sq_res;
        logic [2:0][60:0]      drem;
        logic [2:0][30:0]      quo;
    } item_t;

endpackage

`default_nettype wire

### rtl/cor_axis.sv
// Axis build, block normalisation, squared length and angle reduction stages.
`default_nettype none

module cor_axis import cor_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  in_op,
    input  logic [25:0]           in_angle,
    input  logic [1:0][2:0][31:0] in_vec,
    output logic                  out_valid,
    output item_t                 out_item
);

    logic [4:0] vld_reg;

    item_t             s1_reg, s1_next;
    logic              op1_reg;
    logic [5:0][63:0]  xp1_reg, xp1_next;

    item_t             s2_reg, s2_next;
    logic [63:0]       mag2_reg [3];
    logic [63:0]       mag2_next [3];
    logic signed [64:0] ax [3];

    item_t             s3_reg, s3_next;
    logic [63:0]       orv;
    logic [5:0]        msb;

    item_t             s4_reg;
    logic [59:0]       sq4_reg [3];
    logic [59:0]       sq4_next [3];
    logic signed [ANG_W+25:0] zp4_reg, zp4_next, zsh;

    item_t             out_reg, out_next;

    logic signed [ANG_W-1:0] a1, r2, r3;

    // stage 1: cross products, angle sign
    always_comb begin
        s1_next     = '0;
        s1_next.vec = in_vec;
        a1          = ANG_W'($signed(in_angle));
        if (in_op) begin
            a1 = -a1;
        end
        s1_next.ang = a1;
        xp1_next[0] = $signed(in_vec[1][1]) * $signed(in_vec[0][2]);
        xp1_next[1] = $signed(in_vec[1][2]) * $signed(in_vec[0][1]);
        xp1_next[2] = $signed(in_vec[1][2]) * $signed(in_vec[0][0]);
        xp1_next[3] = $signed(in_vec[1][0]) * $signed(in_vec[0][2]);
        xp1_next[4] = $signed(in_vec[1][0]) * $signed(in_vec[0][1]);
        xp1_next[5] = $signed(in_vec[1][1]) * $signed(in_vec[0][0]);
    end

    // stage 2: axis, magnitudes, zero test, angle modulo a full turn
    always_comb begin
        s2_next = s1_reg;
        for (int i = 0; i < 3; i++) begin
            if (op1_reg) begin
                ax[i] = $signed({xp1_reg[2*i][63], xp1_reg[2*i]})
                      - $signed({xp1_reg[2*i+1][63], xp1_reg[2*i+1]});
            end else begin
                ax[i] = 65'($signed(s1_reg.vec[1][i]));
            end
            mag2_next[i]   = ax[i][64] ? 64'(-ax[i]) : 64'(ax[i]);
            s2_next.sgn[i] = ax[i][64];
        end
        s2_next.zero = (mag2_next[0] == '0) && (mag2_next[1] == '0) && (mag2_next[2] == '0);
        r2 = $signed(s1_reg.ang);
        if (r2 >= ANG_FULL) begin
            r2 = r2 - ANG_FULL;
        end else if (r2 >= 0) begin
            r2 = r2;
        end else if (r2 >= -ANG_FULL) begin
            r2 = r2 + ANG_FULL;
        end else begin
            r2 = r2 + ANG_FULL2;
        end
        s2_next.ang = r2;
    end

    // stage 3: shift so the largest magnitude sits in [2^29, 2^30); angle fold
    always_comb begin
        s3_next = s2_reg;
        orv     = mag2_reg[0] | mag2_reg[1] | mag2_reg[2];
        msb     = '0;
        for (int i = 0; i < 64; i++) begin
            if (orv[i]) begin
                msb = 6'(i);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (msb >= 6'd30) begin
                s3_next.mag[i] = 30'(mag2_reg[i] >> (msb - 6'd29));
            end else begin
                s3_next.mag[i] = 30'(mag2_reg[i] << (6'd29 - msb));
            end
        end
        r3 = $signed(s2_reg.ang);
        if (r3 >= ANG_HALF) begin
            r3 = r3 - ANG_FULL;
        end
        s3_next.flip = 1'b0;
        if (r3 > ANG_QUARTER) begin
            r3 = r3 - ANG_HALF;
            s3_next.flip = 1'b1;
        end else if (r3 < -ANG_QUARTER) begin
            r3 = r3 + ANG_HALF;
            s3_next.flip = 1'b1;
        end
        s3_next.ang = r3;
    end

    // stage 4: squares and degree to radian product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq4_next[i] = s3_reg.mag[i] * s3_reg.mag[i];
        end
        zp4_next = $signed(s3_reg.ang) * DEG_TO_RAD;
    end

    // stage 5: squared length, seed the root, divider and rotator
    always_comb begin
        out_next        = s4_reg;
        out_next.sq_rem = 63'(sq4_reg[0]) + 63'(sq4_reg[1]) + 63'(sq4_reg[2]);
        out_next.sq_res = '0;
        out_next.quo    = '0;
        for (int i = 0; i < 3; i++) begin
            out_next.drem[i] = 61'({s4_reg.mag[i], 30'd0});
        end
        zsh         = zp4_reg >>> FRAC_BITS;
        out_next.cz = 34'(zsh);
        out_next.cx = CORDIC_GAIN;
        out_next.cy = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            op1_reg <= in_op;
            xp1_reg <= xp1_next;
            s2_reg  <= s2_next;
            mag2_reg <= mag2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s3_reg;
            sq4_reg <= sq4_next;
            zp4_reg <= zp4_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_item  = out_reg;

endmodule

`default_nettype wire

### rtl/cor_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
`default_nettype none

module cor_cordic import cor_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    item_t                 stg_reg  [TRIG_STEPS];
    item_t                 stg_next [TRIG_STEPS];
    logic [TRIG_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_stage
        item_t              cur;
        logic signed [33:0] dx, dy;
        logic signed [33:0] at;

        if (k == 0) begin : g_first
            assign cur = in_item;
        end else begin : g_rest
            assign cur = stg_reg[k-1];
        end

        assign dx = $signed(cur.cy) >>> k;
        assign dy = $signed(cur.cx) >>> k;
        assign at = 34'(ATAN_Q30[k]);

        always_comb begin
            stg_next[k] = cur;
            if (!cur.cz[33]) begin
                stg_next[k].cx = cur.cx - dx;
                stg_next[k].cy = cur.cy + dy;
                stg_next[k].cz = cur.cz - at;
            end else begin
                stg_next[k].cx = cur.cx + dx;
                stg_next[k].cy = cur.cy - dy;
                stg_next[k].cz = cur.cz + at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TRIG_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < TRIG_STEPS; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[TRIG_STEPS-1];
    assign out_item  = stg_reg[TRIG_STEPS-1];

endmodule

`default_nettype wire

### rtl/cor_isqrt.sv
// Pipelined integer square root of the squared axis length, one result bit per stage.
`default_nettype none

module cor_isqrt import cor_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    item_t                 stg_reg  [SQRT_STEPS];
    item_t                 stg_next [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
        localparam logic [62:0] BIT = 63'(1) << (2 * (SQRT_STEPS - 1 - k));
        item_t       cur;
        logic [62:0] trial;

        if (k == 0) begin : g_first
            assign cur = in_item;
        end else begin : g_rest
            assign cur = stg_reg[k-1];
        end

        assign trial = cur.sq_res + BIT;

        always_comb begin
            stg_next[k] = cur;
            if (cur.sq_rem >= trial) begin
                stg_next[k].sq_rem = cur.sq_rem - trial;
                stg_next[k].sq_res = (cur.sq_res >> 1) + BIT;
            end else begin
                stg_next[k].sq_res = cur.sq_res >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_item  = stg_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

### rtl/cor_div.sv
// Three-lane restoring divider: magnitude * 2^30 over the root, one quotient bit per stage.
`default_nettype none

module cor_div import cor_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    item_t                stg_reg  [DIV_STEPS];
    item_t                stg_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        localparam int J = DIV_STEPS - 1 - k;
        item_t       cur;
        logic [60:0] trial;

        if (k == 0) begin : g_first
            assign cur = in_item;
        end else begin : g_rest
            assign cur = stg_reg[k-1];
        end

        assign trial = 61'(cur.sq_res[30:0]) << J;

        always_comb begin
            stg_next[k] = cur;
            for (int i = 0; i < 3; i++) begin
                if (cur.drem[i] >= trial) begin
                    stg_next[k].drem[i]   = cur.drem[i] - trial;
                    stg_next[k].quo[i][J] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_item  = stg_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/cor_matrix.sv
// Rodrigues matrix build and matrix-vector products with rounding and saturation.
`default_nettype none

module cor_matrix import cor_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  item_t                 in_item,
    output logic                  out_valid,
    output logic [1:0][2:0][31:0] out_vec,
    output logic                  out_zero
);

    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    function automatic int nn_idx(input int i, input int j);
        if (i == j) begin
            return i;
        end else if (i + j == 1) begin
            return 3;
        end else if (i + j == 2) begin
            return 4;
        end else begin
            return 5;
        end
    endfunction

    logic [5:0] vld_reg;
    item_t      it_reg [5];

    // stage 1
    logic signed [31:0] n1_reg [3];
    logic signed [31:0] n1_next [3];
    logic signed [31:0] c1_reg, c1_next, s1_reg, s1_next;
    logic signed [33:0] xcl, ycl;
    logic [30:0]        u1;

    // stage 2
    logic signed [63:0] pnn [6];
    logic signed [63:0] pns [3];
    logic signed [31:0] nn2_reg [6];
    logic signed [31:0] nn2_next [6];
    logic signed [31:0] ns2_reg [3];
    logic signed [31:0] ns2_next [3];
    logic signed [33:0] t2_reg, t2_next;
    logic signed [31:0] c2_reg;

    // stage 3
    logic signed [65:0] pq [6];
    logic signed [33:0] q3_reg [6];
    logic signed [33:0] q3_next [6];
    logic signed [31:0] ns3_reg [3];
    logic signed [31:0] c3_reg;

    // stage 4
    logic signed [35:0] mm [3][3];
    logic signed [31:0] m4_reg [3][3];
    logic signed [31:0] m4_next [3][3];

    // stage 5
    logic signed [63:0] pr5_reg [2][3][3];
    logic signed [63:0] pr5_next [2][3][3];

    // output stage
    logic signed [65:0]    acc [2][3];
    logic signed [35:0]    shr [2][3];
    logic [1:0][2:0][31:0] vec_reg, vec_next;
    logic                  zero_reg;

    // stage 1: clamp sine, cosine and unit axis, restore signs
    always_comb begin
        xcl = $signed(in_item.cx);
        ycl = $signed(in_item.cy);
        if (xcl > ONE_Q30) begin
            xcl = ONE_Q30;
        end else if (xcl < -ONE_Q30) begin
            xcl = -ONE_Q30;
        end
        if (ycl > ONE_Q30) begin
            ycl = ONE_Q30;
        end else if (ycl < -ONE_Q30) begin
            ycl = -ONE_Q30;
        end
        if (in_item.flip) begin
            xcl = -xcl;
            ycl = -ycl;
        end
        c1_next = 32'(xcl);
        s1_next = 32'(ycl);
        for (int i = 0; i < 3; i++) begin
            u1 = in_item.quo[i];
            if (u1 > 31'(ONE_Q30)) begin
                u1 = 31'(ONE_Q30);
            end
            n1_next[i] = in_item.sgn[i] ? -32'({1'b0, u1}) : 32'({1'b0, u1});
        end
    end

    // stage 2: outer products and sine terms
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            pnn[k]      = n1_reg[PA[k]] * n1_reg[PB[k]];
            nn2_next[k] = 32'(pnn[k] >>> 30);
        end
        for (int i = 0; i < 3; i++) begin
            pns[i]      = n1_reg[i] * s1_reg;
            ns2_next[i] = 32'(pns[i] >>> 30);
        end
        t2_next = ONE_Q30 - 34'(c1_reg);
    end

    // stage 3: scale by one minus cosine
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            pq[k]      = nn2_reg[k] * t2_reg;
            q3_next[k] = 34'(pq[k] >>> 30);
        end
    end

    // stage 4: add cosine on the diagonal and the skew terms, clamp to one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mm[i][j] = 36'(q3_reg[nn_idx(i, j)]) + ((i == j) ? 36'(c3_reg) : 36'sd0);
            end
        end
        mm[0][1] = mm[0][1] - 36'(ns3_reg[2]);
        mm[0][2] = mm[0][2] + 36'(ns3_reg[1]);
        mm[1][0] = mm[1][0] + 36'(ns3_reg[2]);
        mm[1][2] = mm[1][2] - 36'(ns3_reg[0]);
        mm[2][0] = mm[2][0] - 36'(ns3_reg[1]);
        mm[2][1] = mm[2][1] + 36'(ns3_reg[0]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (mm[i][j] > 36'(ONE_Q30)) begin
                    m4_next[i][j] = 32'(ONE_Q30);
                end else if (mm[i][j] < -36'(ONE_Q30)) begin
                    m4_next[i][j] = -32'(ONE_Q30);
                end else begin
                    m4_next[i][j] = 32'(mm[i][j]);
                end
            end
        end
    end

    // stage 5: element products
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pr5_next[k][i][j] = m4_reg[i][j] * $signed(it_reg[3].vec[k][j]);
                end
            end
        end
    end

    // output stage: row sums, round to nearest, saturate; zero axis passes through
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                acc[k][i] = 66'(pr5_reg[k][i][0]) + 66'(pr5_reg[k][i][1])
                          + 66'(pr5_reg[k][i][2]) + 66'sd536870912;
                shr[k][i] = 36'(acc[k][i] >>> 30);
                if (it_reg[4].zero) begin
                    vec_next[k][i] = it_reg[4].vec[k][i];
                end else if (shr[k][i] > 36'sd2147483647) begin
                    vec_next[k][i] = 32'h7fff_ffff;
                end else if (shr[k][i] < -36'sd2147483648) begin
                    vec_next[k][i] = 32'h8000_0000;
                end else begin
                    vec_next[k][i] = shr[k][i][31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg[0] <= in_item;
            for (int k = 1; k < 5; k++) begin
                it_reg[k] <= it_reg[k-1];
            end
            n1_reg   <= n1_next;
            c1_reg   <= c1_next;
            s1_reg   <= s1_next;
            nn2_reg  <= nn2_next;
            ns2_reg  <= ns2_next;
            t2_reg   <= t2_next;
            c2_reg   <= c1_reg;
            q3_reg   <= q3_next;
            ns3_reg  <= ns2_reg;
            c3_reg   <= c2_reg;
            m4_reg   <= m4_next;
            pr5_reg  <= pr5_next;
            vec_reg  <= vec_next;
            zero_reg <= it_reg[4].zero;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_vec   = vec_reg;
    assign out_zero  = zero_reg;

endmodule

`default_nettype wire

### rtl/camera_orbit_rotation.sv
// Top level of the camera orbit rotation pipeline.
`default_nettype none

// Rotates a camera eye and up vector (signed Q16.16) about an axis by an angle in
// degrees, using the Rodrigues matrix. Op 0 orbits left about the normalised up
// vector; op 1 orbits up about the normalised cross(up, eye) by the negated angle.
// Results are rounded to nearest and saturated to 32 bits. If the axis has zero
// length the two vectors come back unchanged with axis_zero set. The block takes one
// word per clock unless stalled and returns one word per word taken, in order. Stages
// from input handshake to output valid: 5 for axis build, normalisation and angle
// reduction, 16 CORDIC stages for sine and cosine, 31 square root stages, 31 divider
// stages for the unit axis and 6 for the matrix and products. Any stall on the
// output freezes the whole pipe; s_ready is low only while a result waits untaken.

module camera_orbit_rotation import cor_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [25:0] s_angle_deg,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_up_x,
    input  logic signed [31:0] s_up_y,
    input  logic signed [31:0] s_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_eye_x,
    output logic signed [31:0] m_new_eye_y,
    output logic signed [31:0] m_new_eye_z,
    output logic signed [31:0] m_new_up_x,
    output logic signed [31:0] m_new_up_y,
    output logic signed [31:0] m_new_up_z,
    output logic               m_axis_zero
);

    logic                  en;
    logic [1:0][2:0][31:0] in_vec;
    logic [1:0][2:0][31:0] out_vec;
    logic                  ax_valid, co_valid, sq_valid, dv_valid;
    item_t                 ax_item, co_item, sq_item, dv_item;

    // whole pipe advances unless a finished word is held at the output
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign in_vec[0][0] = s_eye_x;
    assign in_vec[0][1] = s_eye_y;
    assign in_vec[0][2] = s_eye_z;
    assign in_vec[1][0] = s_up_x;
    assign in_vec[1][1] = s_up_y;
    assign in_vec[1][2] = s_up_z;

    cor_axis u_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_op     (s_op),
        .in_angle  (s_angle_deg),
        .in_vec    (in_vec),
        .out_valid (ax_valid),
        .out_item  (ax_item)
    );

    cor_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ax_valid),
        .in_item   (ax_item),
        .out_valid (co_valid),
        .out_item  (co_item)
    );

    cor_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (co_valid),
        .in_item   (co_item),
        .out_valid (sq_valid),
        .out_item  (sq_item)
    );

    cor_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    cor_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .out_valid (m_valid),
        .out_vec   (out_vec),
        .out_zero  (m_axis_zero)
    );

    assign m_new_eye_x = out_vec[0][0];
    assign m_new_eye_y = out_vec[0][1];
    assign m_new_eye_z = out_vec[0][2];
    assign m_new_up_x  = out_vec[1][0];
    assign m_new_up_y  = out_vec[1][1];
    assign m_new_up_z  = out_vec[1][2];

endmodule

`default_nettype wire

### rtl/cor_checker.sv
// Port-level checks on the camera orbit rotation top, bound to it.
`default_nettype none

module cor_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_new_eye_x,
    input logic signed [31:0] m_new_eye_y,
    input logic signed [31:0] m_new_eye_z,
    input logic signed [31:0] m_new_up_x,
    input logic signed [31:0] m_new_up_y,
    input logic signed [31:0] m_new_up_z,
    input logic               m_axis_zero
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_eye_x) && $stable(m_new_eye_y)
            && $stable(m_new_eye_z) && $stable(m_new_up_x) && $stable(m_new_up_y)
            && $stable(m_new_up_z) && $stable(m_axis_zero))
        else $error("result word changed while stalled");

    // input is refused only while a result waits untaken
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid after reset");

endmodule

bind camera_orbit_rotation cor_checker u_cor_checker (.*);

`default_nettype wire

### sim/camera_orbit_rotation_tb.sv
// Self-checking testbench for the camera orbit rotation pipeline.
`timescale 1ns / 1ps

module camera_orbit_rotation_tb;
    import cor_pkg::*;

    typedef struct {
        logic              op;
        logic signed [25:0] ang;
        logic signed [31:0] eye [3];
        logic signed [31:0] up [3];
    } orbit_word_t;

    typedef struct {
        logic signed [31:0] eye [3];
        logic signed [31:0] up [3];
        logic              zero;
    } pose_t;

    localparam longint LIMIT = 3000000;
    localparam longint Q30 = 64'sd1 << 30;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = 1'b0;
    logic signed [25:0] s_angle_deg = '0;
    logic signed [31:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic signed [31:0] s_up_x = '0, s_up_y = '0, s_up_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_new_eye_x, m_new_eye_y, m_new_eye_z;
    logic signed [31:0] m_new_up_x, m_new_up_y, m_new_up_z;
    logic m_axis_zero;

    orbit_word_t pending_words[$];
    pose_t       expected_poses[$];
    int          mismatches = 0;
    longint      cycle_count = 0;
    bit          stimulus_done = 1'b0;
    bit          hold_sender = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;

    camera_orbit_rotation i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor: fixed-point Rodrigues rotation
    // ---------------------------------------------------------------------
    function automatic longint floor_sh(longint v, int n);
        return v >>> n;   // arithmetic shift floors
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > Q30) return Q30;
        if (v < -Q30) return -Q30;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void trig_of(longint ang, output longint s, output longint c);
        longint full, half, quarter, r, x, y, z, dx, dy;
        bit flip;
        full = longint'(360) << FRAC_BITS;
        half = longint'(180) << FRAC_BITS;
        quarter = longint'(90) << FRAC_BITS;
        r = ang % full;
        flip = 1'b0;
        if (r < 0) r += full;
        if (r >= half) r -= full;
        if (r > quarter) begin
            r -= half;
            flip = 1'b1;
        end else if (r < -quarter) begin
            r += half;
            flip = 1'b1;
        end
        z = (r * longint'(DEG_TO_RAD)) >>> FRAC_BITS;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic pose_t orbit_pose(orbit_word_t w);
        pose_t p;
        longint vec [2][3];
        longint axis [3], nrm [3], rot [3][3];
        longint unsigned mag [3], mx, len2, root, u;
        longint ang, s, c, t, acc;
        ang = w.ang;
        for (int i = 0; i < 3; i++) begin
            vec[0][i] = w.eye[i];
            vec[1][i] = w.up[i];
        end
        if (!w.op) begin
            for (int i = 0; i < 3; i++) axis[i] = vec[1][i];
        end else begin
            axis[0] = vec[1][1] * vec[0][2] - vec[1][2] * vec[0][1];
            axis[1] = vec[1][2] * vec[0][0] - vec[1][0] * vec[0][2];
            axis[2] = vec[1][0] * vec[0][1] - vec[1][1] * vec[0][0];
            ang = -ang;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = axis[i] < 0 ? -axis[i] : axis[i];
            if (mag[i] > mx) mx = mag[i];
        end
        p.eye = w.eye;
        p.up = w.up;
        p.zero = 1'b1;
        if (mx == 0) return p;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        root = int_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            u = (mag[i] << 30) / root;
            if (u > 64'd1 << 30) u = 64'd1 << 30;
            nrm[i] = axis[i] < 0 ? -longint'(u) : longint'(u);
        end
        trig_of(ang, s, c);
        t = Q30 - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = qmul(qmul(nrm[i], nrm[j]), t) + (i == j ? c : 0);
        rot[0][1] -= qmul(nrm[2], s);
        rot[0][2] += qmul(nrm[1], s);
        rot[1][0] += qmul(nrm[2], s);
        rot[1][2] -= qmul(nrm[0], s);
        rot[2][0] -= qmul(nrm[1], s);
        rot[2][1] += qmul(nrm[0], s);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = clamp_unit(rot[i][j]);
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                acc = rot[i][0] * vec[k][0] + rot[i][1] * vec[k][1]
                    + rot[i][2] * vec[k][2];
                acc = (acc + (64'sd1 << 29)) >>> 30;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                if (k == 0) p.eye[i] = acc[31:0];
                else p.up[i] = acc[31:0];
            end
        end
        p.zero = 1'b0;
        return p;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;                                    // full range
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 8))) - 4;      // tiny
            default: return 32'($signed($urandom_range(0, 20 << 16))) - (10 << 16);
        endcase
    endfunction

    function automatic logic signed [25:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 26'($urandom);                               // any bits, wraps
            1: return 26'($signed($urandom_range(0, 8)) - 4) * 26'sd5898240; // 90 steps
            default: return 26'($signed($urandom_range(0, 47185920)) - 23592960);
        endcase
    endfunction

    task automatic queue_word(logic op, logic signed [25:0] ang,
                              logic signed [31:0] ex, logic signed [31:0] ey,
                              logic signed [31:0] ez, logic signed [31:0] ux,
                              logic signed [31:0] uy, logic signed [31:0] uz);
        orbit_word_t w;
        w.op = op;
        w.ang = ang;
        w.eye = '{ex, ey, ez};
        w.up = '{ux, uy, uz};
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(string field, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, field, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Driver: bursts and gaps, payload held until taken
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_poses.push_back(orbit_pose(pending_words.pop_front()));
            end
            if (!(s_valid && !s_ready)) begin
                // free to present a new word this cycle
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > (s_valid && s_ready ? 0 : 0)
                             && !hold_sender && pending_words.size() != 0) begin
                    s_valid <= 1'b1;
                    s_op <= pending_words[0].op;
                    s_angle_deg <= pending_words[0].ang;
                    s_eye_x <= pending_words[0].eye[0];
                    s_eye_y <= pending_words[0].eye[1];
                    s_eye_z <= pending_words[0].eye[2];
                    s_up_x <= pending_words[0].up[0];
                    s_up_y <= pending_words[0].up[1];
                    s_up_z <= pending_words[0].up[2];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: receiver stall pattern and compare against oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        pose_t want;
        cycle_count++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    $display("unexpected word at cycle %0d", cycle_count);
                    mismatches++;
                end else begin
                    want = expected_poses.pop_front();
                    if (m_new_eye_x !== want.eye[0]) report_mismatch("new_eye_x", m_new_eye_x, want.eye[0]);
                    if (m_new_eye_y !== want.eye[1]) report_mismatch("new_eye_y", m_new_eye_y, want.eye[1]);
                    if (m_new_eye_z !== want.eye[2]) report_mismatch("new_eye_z", m_new_eye_z, want.eye[2]);
                    if (m_new_up_x !== want.up[0]) report_mismatch("new_up_x", m_new_up_x, want.up[0]);
                    if (m_new_up_y !== want.up[1]) report_mismatch("new_up_y", m_new_up_y, want.up[1]);
                    if (m_new_up_z !== want.up[2]) report_mismatch("new_up_z", m_new_up_z, want.up[2]);
                    if (m_axis_zero !== want.zero)
                        report_mismatch("axis_zero", 32'(m_axis_zero), 32'(want.zero));
                end
            end
            // stall in phases of its own: long free-flow stretches, then choppy ones
            if ((cycle_count / 500) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
        if (cycle_count > LIMIT) begin
            $display("camera_orbit_rotation test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        logic signed [31:0] ex, ey, ez;
        int k;
        // directed: extremes, both ops, zero axis cases, angle folds and wraps
        queue_word(1'b0, 26'sd5898240, 1 << 16, 0, 0, 0, 1 << 16, 0);
        queue_word(1'b1, 26'sd5898240, 0, 0, 1 << 16, 0, 1 << 16, 0);
        queue_word(1'b0, 26'sd11796480, 1 << 16, 2 << 16, 3 << 16, 0, 0, 1 << 16);
        queue_word(1'b0, 26'sd23592960, 5 << 16, 0, -3 << 16, 0, 1 << 16, 0);
        queue_word(1'b0, -26'sd23592960, 5 << 16, 1, -3 << 16, 1 << 16, 1 << 16, 0);
        queue_word(1'b1, -26'sd11796480, 1 << 16, 0, 0, 0, 0, 1 << 16);
        queue_word(1'b0, 26'sd1234567, 7, -9, 3, 0, 0, 0);                  // zero up
        queue_word(1'b1, 26'sd1234567, 2 << 16, 4 << 16, 6 << 16, 1 << 16, 2 << 16, 3 << 16);
        queue_word(1'b1, 26'sd100, 0, 0, 0, 1 << 16, 0, 0);                 // zero eye
        queue_word(1'b0, 26'sh1ffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        queue_word(1'b0, 26'sh2000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_word(1'b1, 26'sh1ffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 32'sh00000001);
        queue_word(1'b1, 26'sh2000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        queue_word(1'b0, 26'sd0, 3 << 16, 4 << 16, 5 << 16, 1, 1, 1);
        queue_word(1'b0, 26'sd5898241, 1 << 16, 0, 0, 0, 0, -1);
        queue_word(1'b0, -26'sd5898241, 1 << 16, 0, 0, 0, 0, 32'sh80000000);
        queue_word(1'b1, 26'sd17694720, 1 << 16, 1 << 16, 0, -1 << 16, 1 << 16, 0);
        queue_word(1'b0, 26'sd11796479, -1, -1, -1, 1, 0, 0);

        @(posedge aclk);
        @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < 1850; k++) begin
            ex = rand_comp(); ey = rand_comp(); ez = rand_comp();
            if ($urandom_range(0, 19) == 0) begin
                // up copies eye with x or y zeroed at random: equal up and eye give a zero-axis corner
                queue_word($urandom_range(0, 1), rand_angle(), ex, ey, ez,
                           $urandom_range(0, 1) ? ex : 32'sd0,
                           $urandom_range(0, 1) ? ey : 32'sd0, ez);
            end else begin
                queue_word($urandom_range(0, 1), rand_angle(), ex, ey, ez,
                           rand_comp(), rand_comp(), rand_comp());
            end
            // once the pipe is busy, hold the sender until it drains
            if (k == 900) begin
                wait (pending_words.size() == 0);
                hold_sender = 1'b1;
                wait (expected_poses.size() == 0 && !s_valid);
                hold_sender = 1'b0;
            end
        end

        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_poses.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("camera_orbit_rotation test passed");
        end else begin
            $display("camera_orbit_rotation test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cor_pkg.sv
rtl/cor_axis.sv
rtl/cor_cordic.sv
rtl/cor_isqrt.sv
rtl/cor_div.sv
rtl/cor_matrix.sv
rtl/camera_orbit_rotation.sv
rtl/cor_checker.sv
sim/camera_orbit_rotation_tb.sv
